/* rtl/bgrr_pkg.sv */
// ----------------------------------------------------------------------------
// bgrr_pkg: bitmap glyph row rasterizer package
// Sizes, command and register codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package bgrr_pkg;

  localparam int FONT_BYTES    = 4096;
  localparam int FONT_AW       = $clog2(FONT_BYTES);
  localparam int GLYPH_COUNT   = 11;
  localparam int GLYPH_AW      = $clog2(GLYPH_COUNT);
  localparam int MAX_ROWS      = 32;
  localparam int ROW_BITS      = 64;
  localparam int MAX_ROW_BYTES = 8;
  localparam int ACC_BITS      = MAX_ROW_BYTES * 8;
  localparam int ROW_IDX_W     = $clog2(MAX_ROWS);
  localparam int BYTE_IDX_W    = $clog2(MAX_ROW_BYTES);
  localparam int POS_W         = $clog2(MAX_ROWS * MAX_ROW_BYTES) + 1;
  localparam int OFFSET_W      = 12;
  localparam int SUM_W         = ((OFFSET_W > POS_W) ? OFFSET_W : POS_W) + 2;
  localparam int CENTER_ROWS   = 32;
  localparam int CFG_W         = 16;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    CMD_FONT_BYTE   = 2'd0,
    CMD_GLYPH_ENTRY = 2'd1,
    CMD_DRAW        = 2'd2,
    CMD_NOP         = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_FONT_HEIGHT     = 3'd0,
    CFG_FONT_BYTES_USED = 3'd1,
    CFG_REVEAL_ROWS     = 3'd2,
    CFG_SPARKLE_ENABLE  = 3'd3,
    CFG_SPARKLE_COLOR   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]  font_height;
    logic [12:0] font_bytes_used;
    logic [4:0]  reveal_rows;
    logic        sparkle_enable;
  } cfg_t;

  typedef struct packed {
    logic [5:0]          width;
    logic [OFFSET_W-1:0] offset;
  } glyph_entry_t;

  typedef struct packed {
    logic       step;
    logic [7:0] bits;
  } spk_req_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

  // base-4 digit sum keeps the value mod 3
  function automatic logic mod3_zero(input logic [15:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

/* rtl/bitmap_glyph_row_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// bitmap_glyph_row_rasterizer_core: bitmap glyph row rasterizer top level
// Font byte store and glyph table in RAM; draws emit one masked row per
// glyph row.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   command_i .. draw_color_i
//   result   out        out_valid_o / out_ready_i row_x_o .. last_row_o
//   config   in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// Load items are written when accepted. A draw looks up the glyph entry, reads
// its font bytes (rows * (width/8+1)) on the font RAM port, assembles each row
// and goes back to idle; a row's last byte is not read while the previous row's
// last byte is still returning. Invalid glyphs and zero-row draws skip the reads
// and emit a single empty row. A stalled result holds the read of the next row's
// last byte. Reset is asynchronous; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_rasterizer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [11:0]                   byte_address_i,
  input  logic [7:0]                    byte_value_i,
  input  logic [3:0]                    entry_index_i,
  input  logic [5:0]                    entry_width_i,
  input  logic [11:0]                   entry_offset_i,
  input  logic signed [7:0]             glyph_i,
  input  logic signed [7:0]             pos_x_i,
  input  logic signed [7:0]             pos_y_i,
  input  logic [15:0]                   draw_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [7:0]             row_x_o,
  output logic signed [8:0]             row_y_o,
  output logic [bgrr_pkg::ROW_BITS-1:0] pixel_mask_o,
  output logic [bgrr_pkg::ROW_BITS-1:0] sparkle_mask_o,
  output logic [15:0]                   pixel_color_o,
  output logic [5:0]                    glyph_width_o,
  output logic                          last_row_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [bgrr_pkg::CFG_W-1:0]    cfg_data_i
);

  bgrr_pkg::cfg_t         cfg_q;
  bgrr_pkg::glyph_entry_t entry_wdata;
  bgrr_pkg::glyph_entry_t entry_rdata;
  bgrr_pkg::spk_req_t     spk_req;

  logic                         accept;
  logic                         glyph_ok;
  logic                         idle;
  logic                         font_re;
  logic [bgrr_pkg::FONT_AW-1:0] font_raddr;
  logic [7:0]                   font_rdata;
  logic [7:0]                   spk_bits;

  assign in_ready_o = idle;
  assign accept     = in_valid_i && in_ready_o;
  assign glyph_ok   = $unsigned(glyph_i) < 8'(bgrr_pkg::GLYPH_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_height     <= 6'd16;
      cfg_q.font_bytes_used <= '0;
      cfg_q.reveal_rows     <= '0;
      cfg_q.sparkle_enable  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bgrr_pkg::CFG_FONT_HEIGHT:     cfg_q.font_height     <= cfg_data_i[5:0];
        bgrr_pkg::CFG_FONT_BYTES_USED: cfg_q.font_bytes_used <= cfg_data_i[12:0];
        bgrr_pkg::CFG_REVEAL_ROWS:     cfg_q.reveal_rows     <= cfg_data_i[4:0];
        bgrr_pkg::CFG_SPARKLE_ENABLE:  cfg_q.sparkle_enable  <= cfg_data_i[0];
        bgrr_pkg::CFG_SPARKLE_COLOR: begin
          // applied by the display side
        end
        default: begin
        end
      endcase
    end
  end

  bgrr_ram #(
    .WIDTH (8),
    .DEPTH (bgrr_pkg::FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (command_i == bgrr_pkg::CMD_FONT_BYTE)),
    .waddr_i (byte_address_i[bgrr_pkg::FONT_AW-1:0]),
    .wdata_i (byte_value_i),
    .re_i    (font_re),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  assign entry_wdata.width  = entry_width_i;
  assign entry_wdata.offset = entry_offset_i;

  bgrr_ram #(
    .WIDTH ($bits(bgrr_pkg::glyph_entry_t)),
    .DEPTH (bgrr_pkg::GLYPH_COUNT)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (command_i == bgrr_pkg::CMD_GLYPH_ENTRY) &&
              (entry_index_i < 4'(bgrr_pkg::GLYPH_COUNT))),
    .waddr_i (entry_index_i[bgrr_pkg::GLYPH_AW-1:0]),
    .wdata_i (entry_wdata),
    .re_i    (accept && (command_i == bgrr_pkg::CMD_DRAW) && glyph_ok),
    .raddr_i (glyph_i[bgrr_pkg::GLYPH_AW-1:0]),
    .rdata_o (entry_rdata)
  );

  bgrr_sparkle u_sparkle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (spk_req),
    .spk_o  (spk_bits)
  );

  bgrr_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (accept && (command_i == bgrr_pkg::CMD_DRAW)),
    .glyph_ok_i     (glyph_ok),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .draw_color_i   (draw_color_i),
    .cfg_i          (cfg_q),
    .entry_i        (entry_rdata),
    .font_re_o      (font_re),
    .font_raddr_o   (font_raddr),
    .font_rdata_i   (font_rdata),
    .spk_req_o      (spk_req),
    .spk_i          (spk_bits),
    .idle_o         (idle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_x_o        (row_x_o),
    .row_y_o        (row_y_o),
    .pixel_mask_o   (pixel_mask_o),
    .sparkle_mask_o (sparkle_mask_o),
    .pixel_color_o  (pixel_color_o),
    .glyph_width_o  (glyph_width_o),
    .last_row_o     (last_row_o)
  );

endmodule

/* rtl/bgrr_ram.sv */
// ----------------------------------------------------------------------------
// bgrr_ram: generic single-port-write RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bgrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/bgrr_sparkle.sv */
// ----------------------------------------------------------------------------
// bgrr_sparkle: sparkle pixel picker
// Galois LFSR stepped once per set pixel of a font byte, MSB pixel first.
// ----------------------------------------------------------------------------
module bgrr_sparkle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgrr_pkg::spk_req_t req_i,
  output logic [7:0]         spk_o
);

  logic [15:0] lfsr_q, lfsr_d;

  always_comb begin
    logic [15:0] l;
    l = lfsr_q;
    spk_o = '0;
    for (int k = 0; k < 8; k++) begin
      if (req_i.bits[k]) begin
        l = bgrr_pkg::lfsr_next(l);
        spk_o[k] = req_i.step && bgrr_pkg::mod3_zero(l);
      end
    end
    lfsr_d = req_i.step ? l : lfsr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= bgrr_pkg::LFSR_SEED;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule

/* rtl/bgrr_engine.sv */
// ----------------------------------------------------------------------------
// bgrr_engine: draw sequencer
// Glyph lookup, font byte read pipeline, row assembly and output register.
// ----------------------------------------------------------------------------
module bgrr_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 glyph_ok_i,
  input  logic signed [7:0]                    pos_x_i,
  input  logic signed [7:0]                    pos_y_i,
  input  logic [15:0]                          draw_color_i,
  input  bgrr_pkg::cfg_t                       cfg_i,
  input  bgrr_pkg::glyph_entry_t               entry_i,
  output logic                                 font_re_o,
  output logic [bgrr_pkg::FONT_AW-1:0]         font_raddr_o,
  input  logic [7:0]                           font_rdata_i,
  output bgrr_pkg::spk_req_t                   spk_req_o,
  input  logic [7:0]                           spk_i,
  output logic                                 idle_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [7:0]                    row_x_o,
  output logic signed [8:0]                    row_y_o,
  output logic [bgrr_pkg::ROW_BITS-1:0]        pixel_mask_o,
  output logic [bgrr_pkg::ROW_BITS-1:0]        sparkle_mask_o,
  output logic [15:0]                          pixel_color_o,
  output logic [5:0]                           glyph_width_o,
  output logic                                 last_row_o
);

  localparam int RW = bgrr_pkg::ROW_IDX_W;
  localparam int BW = bgrr_pkg::BYTE_IDX_W;
  localparam int PW = bgrr_pkg::POS_W;
  localparam int SW = bgrr_pkg::SUM_W;
  localparam int AB = bgrr_pkg::ACC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_SINGLE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [7:0]            x_q, x_d;
  logic signed [8:0]            y_q, y_d;
  logic [15:0]                  color_q, color_d;
  logic                         ok_q, ok_d;
  logic                         spk_on_q, spk_on_d;
  logic [5:0]                   width_q, width_d;
  logic [bgrr_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [RW-1:0]                last_row_q, last_row_d;
  logic [BW-1:0]                last_byte_q, last_byte_d;
  logic [RW-1:0]                row_q, row_d;
  logic [BW-1:0]                byte_q, byte_d;
  logic [PW-1:0]                pos_q, pos_d;
  logic                         done_q, done_d;
  logic                         rd_valid_q, rd_valid_d;
  logic [BW-1:0]                rd_byte_q, rd_byte_d;
  logic                         rd_last_q, rd_last_d;
  logic                         rd_final_q, rd_final_d;
  logic [RW-1:0]                rd_row_q, rd_row_d;
  logic [AB-1:0]                pix_acc_q, pix_acc_d;
  logic [AB-1:0]                spk_acc_q, spk_acc_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [7:0]            row_x_q, row_x_d;
  logic signed [8:0]            row_y_q, row_y_d;
  logic [bgrr_pkg::ROW_BITS-1:0] pix_q, pix_d;
  logic [bgrr_pkg::ROW_BITS-1:0] spk_q, spk_d;
  logic [15:0]                  pcol_q, pcol_d;
  logic [5:0]                   gw_q, gw_d;
  logic                         last_q, last_d;

  logic                         out_free;
  logic                         is_last_byte;
  logic                         is_final;
  logic                         issue;
  logic [SW-1:0]                addr_sum;
  logic [7:0]                   col_bits;

  assign out_free     = !out_valid_q || out_ready_i;
  assign is_last_byte = (byte_q == last_byte_q);
  assign is_final     = is_last_byte && (row_q == last_row_q);
  // a row's last byte is read only when the output register will be free
  assign issue        = (state_q == ST_RUN) && !done_q &&
                        (!is_last_byte || (out_free && !(rd_valid_q && rd_last_q)));
  assign addr_sum     = SW'(offset_q) + SW'(pos_q);
  assign font_re_o    = issue;
  assign font_raddr_o = addr_sum[bgrr_pkg::FONT_AW-1:0];

  always_comb begin
    logic [7:0] rev;
    rev = bgrr_pkg::bit_rev8(font_rdata_i);
    for (int k = 0; k < 8; k++) begin
      col_bits[k] = rev[k] && ((int'(rd_byte_q) * 8 + k) < bgrr_pkg::ROW_BITS);
    end
  end

  assign spk_req_o.step = rd_valid_q && spk_on_q;
  assign spk_req_o.bits = col_bits;

  always_comb begin
    logic signed [6:0] dif;
    logic signed [6:0] half;
    logic [5:0]        rows;
    logic [AB-1:0]     new_pix;
    logic [AB-1:0]     new_spk;

    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    color_d     = color_q;
    ok_d        = ok_q;
    spk_on_d    = spk_on_q;
    width_d     = width_q;
    offset_d    = offset_q;
    last_row_d  = last_row_q;
    last_byte_d = last_byte_q;
    row_d       = row_q;
    byte_d      = byte_q;
    pos_d       = pos_q;
    done_d      = done_q;
    rd_valid_d  = issue;
    rd_byte_d   = byte_q;
    rd_last_d   = is_last_byte;
    rd_final_d  = is_final;
    rd_row_d    = row_q;
    pix_acc_d   = pix_acc_q;
    spk_acc_d   = spk_acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    row_x_d     = row_x_q;
    row_y_d     = row_y_q;
    pix_d       = pix_q;
    spk_d       = spk_q;
    pcol_d      = pcol_q;
    gw_d        = gw_q;
    last_d      = last_q;

    dif  = 7'(bgrr_pkg::CENTER_ROWS) - {1'b0, cfg_i.font_height};
    half = $signed(dif + {6'b0, dif[6]}) >>> 1;

    rows = cfg_i.font_height;
    if ((cfg_i.reveal_rows != '0) && ({1'b0, cfg_i.reveal_rows} < cfg_i.font_height)) begin
      rows = {1'b0, cfg_i.reveal_rows};
    end
    if (rows > 6'(bgrr_pkg::MAX_ROWS)) begin
      rows = 6'(bgrr_pkg::MAX_ROWS);
    end

    new_pix = ((rd_byte_q == '0) ? '0 : pix_acc_q) | (AB'(col_bits) << {rd_byte_q, 3'b000});
    new_spk = ((rd_byte_q == '0) ? '0 : spk_acc_q) | (AB'(spk_i) << {rd_byte_q, 3'b000});

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d      = pos_x_i;
          y_d      = pos_y_i[7] ? {{2{half[6]}}, half} : {pos_y_i[7], pos_y_i};
          color_d  = draw_color_i;
          ok_d     = glyph_ok_i;
          spk_on_d = (draw_color_i != '0) && cfg_i.sparkle_enable;
          state_d  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        width_d     = ok_q ? entry_i.width : '0;
        offset_d    = entry_i.offset;
        last_row_d  = RW'(rows - 6'd1);
        last_byte_d = BW'(entry_i.width >> 3);
        row_d       = '0;
        byte_d      = '0;
        pos_d       = '0;
        done_d      = 1'b0;
        state_d     = (!ok_q || (rows == '0)) ? ST_SINGLE : ST_RUN;
      end
      ST_RUN: begin
        if (issue) begin
          if ((addr_sum + SW'(1)) < SW'(cfg_i.font_bytes_used)) begin
            pos_d = pos_q + PW'(1);
          end
          if (is_last_byte) begin
            byte_d = '0;
            row_d  = row_q + RW'(1);
          end else begin
            byte_d = byte_q + BW'(1);
          end
          done_d = is_final;
        end
        if (rd_valid_q) begin
          pix_acc_d = new_pix;
          spk_acc_d = new_spk;
          if (rd_last_q) begin
            out_valid_d = 1'b1;
            row_x_d     = x_q;
            row_y_d     = y_q + 9'(rd_row_q);
            pix_d       = new_pix[bgrr_pkg::ROW_BITS-1:0];
            spk_d       = new_spk[bgrr_pkg::ROW_BITS-1:0];
            pcol_d      = color_q;
            gw_d        = width_q;
            last_d      = rd_final_q;
            if (rd_final_q) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          row_x_d     = x_q;
          row_y_d     = y_q;
          pix_d       = '0;
          spk_d       = '0;
          pcol_d      = color_q;
          gw_d        = width_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    color_q     <= color_d;
    ok_q        <= ok_d;
    spk_on_q    <= spk_on_d;
    width_q     <= width_d;
    offset_q    <= offset_d;
    last_row_q  <= last_row_d;
    last_byte_q <= last_byte_d;
    row_q       <= row_d;
    byte_q      <= byte_d;
    pos_q       <= pos_d;
    rd_byte_q   <= rd_byte_d;
    rd_last_q   <= rd_last_d;
    rd_final_q  <= rd_final_d;
    rd_row_q    <= rd_row_d;
    pix_acc_q   <= pix_acc_d;
    spk_acc_q   <= spk_acc_d;
    row_x_q     <= row_x_d;
    row_y_q     <= row_y_d;
    pix_q       <= pix_d;
    spk_q       <= spk_d;
    pcol_q      <= pcol_d;
    gw_q        <= gw_d;
    last_q      <= last_d;
  end

  assign idle_o         = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign row_x_o        = row_x_q;
  assign row_y_o        = row_y_q;
  assign pixel_mask_o   = pix_q;
  assign sparkle_mask_o = spk_q;
  assign pixel_color_o  = pcol_q;
  assign glyph_width_o  = gw_q;
  assign last_row_o     = last_q;

endmodule

/* rtl/bgrr_checker.sv */
// ----------------------------------------------------------------------------
// bgrr_checker: port-level checks for the rasterizer top level
// Bound to bitmap_glyph_row_rasterizer_core.
// ----------------------------------------------------------------------------
module bgrr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    command_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [8:0]             row_y_o,
  input logic [bgrr_pkg::ROW_BITS-1:0] pixel_mask_o,
  input logic [bgrr_pkg::ROW_BITS-1:0] sparkle_mask_o,
  input logic [5:0]                    glyph_width_o,
  input logic                          last_row_o
);

  // a draw transfer closes the input for the glyph lookup
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == bgrr_pkg::CMD_DRAW)) |=> !in_ready_o)
    else $error("input ready right after a draw transfer");

  // the input stays closed until the final row of a draw is out
  a_rows_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_row_o) |-> !in_ready_o)
    else $error("input ready while draw rows remain");

  a_spk_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sparkle_mask_o & ~pixel_mask_o) == '0))
    else $error("sparkle bit on an undrawn pixel");

  a_mask_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pixel_mask_o >> ({1'b0, glyph_width_o[5:3], 3'b000} + 7'd8)) == '0))
    else $error("pixel beyond the glyph's row bytes");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pixel_mask_o) && $stable(row_y_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_glyph_row_rasterizer_core bgrr_checker u_bgrr_checker (.*);

/* test/glyph_row_checker.sv */
// ----------------------------------------------------------------------------
// glyph_row_checker: row predictor and comparator for the glyph rasterizer
// Tracks font bytes, glyph entries, register settings and the sparkle LFSR
// from the observed transfers. Each accepted draw queues its expected rows.
// Each accepted row is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module glyph_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    command_i,
  input  logic [11:0]                   byte_address_i,
  input  logic [7:0]                    byte_value_i,
  input  logic [3:0]                    entry_index_i,
  input  logic [5:0]                    entry_width_i,
  input  logic [11:0]                   entry_offset_i,
  input  logic signed [7:0]             glyph_i,
  input  logic signed [7:0]             pos_x_i,
  input  logic signed [7:0]             pos_y_i,
  input  logic [15:0]                   draw_color_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [7:0]             row_x_i,
  input  logic signed [8:0]             row_y_i,
  input  logic [bgrr_pkg::ROW_BITS-1:0] pixel_mask_i,
  input  logic [bgrr_pkg::ROW_BITS-1:0] sparkle_mask_i,
  input  logic [15:0]                   pixel_color_i,
  input  logic [5:0]                    glyph_width_i,
  input  logic                          last_row_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [bgrr_pkg::CFG_W-1:0]    cfg_data_i,
  output int                            error_count,
  output int                            rows_pending,
  output int                            rows_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]                    x;
    logic [8:0]                    y;
    logic [bgrr_pkg::ROW_BITS-1:0] pix;
    logic [bgrr_pkg::ROW_BITS-1:0] spk;
    logic [15:0]                   color;
    logic [5:0]                    width;
    logic                          last;
  } glyph_row_t;

  glyph_row_t expected_rows[$];

  logic [7:0]  font_image [bgrr_pkg::FONT_BYTES];
  logic [5:0]  entry_width [bgrr_pkg::GLYPH_COUNT];
  logic [11:0] entry_offset [bgrr_pkg::GLYPH_COUNT];
  logic [15:0] sparkle_state;

  logic [5:0]  font_height;
  logic [12:0] bytes_used;
  logic [4:0]  reveal_rows;
  logic        sparkle_en;
  logic [15:0] sparkle_color;

  initial begin
    error_count  = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  task automatic predict_rows(input logic [7:0] glyph, input logic signed [7:0] x,
                              input logic signed [7:0] y, input logic [15:0] color);
    glyph_row_t row;
    int         top_row;
    int         g;
    int         width;
    int         wround;
    int         off;
    int         rows;
    int         pos;
    int         bit_idx;
    logic [7:0] cur_byte;
    logic       sparkling;
    top_row = y;
    if (top_row < 0) top_row = (bgrr_pkg::CENTER_ROWS - int'(font_height)) / 2;
    g = int'(glyph);
    row.x = x;
    row.color = color;
    row.pix = '0;
    row.spk = '0;
    row.y = 9'(top_row);
    row.last = 1'b1;
    if (g >= bgrr_pkg::GLYPH_COUNT) begin
      row.width = '0;
      expected_rows.push_back(row);
      return;
    end
    width = int'(entry_width[g]);
    wround = (width / 8 + 1) * 8;
    off = int'(entry_offset[g]);
    row.width = entry_width[g];
    rows = font_height;
    if (reveal_rows > 0 && reveal_rows < font_height) rows = reveal_rows;
    if (rows > bgrr_pkg::MAX_ROWS) rows = bgrr_pkg::MAX_ROWS;
    if (rows == 0) begin
      expected_rows.push_back(row);
      return;
    end
    sparkling = (color != 16'h0) && sparkle_en;
    pos = 0;
    for (int yy = 0; yy < rows; yy++) begin
      row.pix = '0;
      row.spk = '0;
      bit_idx = 7;
      cur_byte = font_image[(off + pos) % bgrr_pkg::FONT_BYTES];
      for (int xx = 0; xx < wround; xx++) begin
        if (cur_byte[bit_idx] && xx < bgrr_pkg::ROW_BITS) begin
          row.pix[xx] = 1'b1;
          if (sparkling) begin
            sparkle_state = sparkle_state[0] ? ((sparkle_state >> 1) ^ bgrr_pkg::LFSR_TAPS)
                                             : (sparkle_state >> 1);
            if (sparkle_state % 3 == 0) row.spk[xx] = 1'b1;
          end
        end
        bit_idx--;
        if (bit_idx < 0) begin
          bit_idx = 7;
          if (pos + off + 1 < int'(bytes_used)) begin
            pos++;
            cur_byte = font_image[(off + pos) % bgrr_pkg::FONT_BYTES];
          end
        end
      end
      row.y = 9'(top_row + yy);
      row.last = (yy == rows - 1);
      expected_rows.push_back(row);
    end
  endtask

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_row();
    glyph_row_t want;
    int         nbad;
    rows_checked++;
    if (expected_rows.size() == 0) begin
      error_count++;
      $display("%0t ns: unexpected row, expected none, got x %0d y %0d pix %h last %b",
               $time, row_x_i, row_y_i, pixel_mask_i, last_row_i);
      return;
    end
    want = expected_rows.pop_front();
    nbad = field_differs("row_x", want.x, row_x_i[7:0])
         + field_differs("row_y", want.y, row_y_i[8:0])
         + field_differs("pixel_mask", want.pix, pixel_mask_i)
         + field_differs("sparkle_mask", want.spk, sparkle_mask_i)
         + field_differs("pixel_color", want.color, pixel_color_i)
         + field_differs("glyph_width", want.width, glyph_width_i)
         + field_differs("last_row", want.last, last_row_i);
    error_count += nbad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_height   = 6'd16;
      bytes_used    = '0;
      reveal_rows   = '0;
      sparkle_en    = 1'b0;
      sparkle_color = 16'hFFFF;
      sparkle_state = bgrr_pkg::LFSR_SEED;
      expected_rows.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_row();
      if (cfg_we_i) begin
        case (cfg_index_i)
          bgrr_pkg::CFG_FONT_HEIGHT:     font_height   = cfg_data_i[5:0];
          bgrr_pkg::CFG_FONT_BYTES_USED: bytes_used    = cfg_data_i[12:0];
          bgrr_pkg::CFG_REVEAL_ROWS:     reveal_rows   = cfg_data_i[4:0];
          bgrr_pkg::CFG_SPARKLE_ENABLE:  sparkle_en    = cfg_data_i[0];
          bgrr_pkg::CFG_SPARKLE_COLOR:   sparkle_color = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (command_i)
          bgrr_pkg::CMD_FONT_BYTE: font_image[byte_address_i] = byte_value_i;
          bgrr_pkg::CMD_GLYPH_ENTRY: begin
            if (entry_index_i < bgrr_pkg::GLYPH_COUNT) begin
              entry_width[entry_index_i]  = entry_width_i;
              entry_offset[entry_index_i] = entry_offset_i;
            end
          end
          bgrr_pkg::CMD_DRAW: predict_rows(glyph_i, pos_x_i, pos_y_i, draw_color_i);
          default: ;
        endcase
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

/* test/bitmap_glyph_row_rasterizer_core_test.sv */
// ----------------------------------------------------------------------------
// bitmap_glyph_row_rasterizer_core_test: testbench top for the rasterizer
// Directed loads and draws, then random load/draw sequences under several
// register settings with bursty input and a stalling row sink. Rows are
// predicted and compared in glyph_row_checker.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_rasterizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    bgrr_pkg::cmd_e cmd;
    logic [11:0]    addr;
    logic [7:0]     value;
    logic [3:0]     idx;
    logic [5:0]     w;
    logic [11:0]    off;
    logic [7:0]     glyph;
    logic [7:0]     x;
    logic [7:0]     y;
    logic [15:0]    color;
  } raster_cmd_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    command_i = '0;
  logic [11:0]                   byte_address_i = '0;
  logic [7:0]                    byte_value_i = '0;
  logic [3:0]                    entry_index_i = '0;
  logic [5:0]                    entry_width_i = '0;
  logic [11:0]                   entry_offset_i = '0;
  logic signed [7:0]             glyph_i = '0;
  logic signed [7:0]             pos_x_i = '0;
  logic signed [7:0]             pos_y_i = '0;
  logic [15:0]                   draw_color_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [7:0]             row_x_o;
  logic signed [8:0]             row_y_o;
  logic [bgrr_pkg::ROW_BITS-1:0] pixel_mask_o;
  logic [bgrr_pkg::ROW_BITS-1:0] sparkle_mask_o;
  logic [15:0]                   pixel_color_o;
  logic [5:0]                    glyph_width_o;
  logic                          last_row_o;
  logic                          cfg_we_i = 1'b0;
  logic [2:0]                    cfg_index_i = '0;
  logic [bgrr_pkg::CFG_W-1:0]    cfg_data_i = '0;

  int error_count;
  int rows_pending;
  int rows_checked;

  // stimulus-side bookkeeping: which font bytes and entries hold known data
  bit          font_known [bgrr_pkg::FONT_BYTES];
  bit          entry_known [bgrr_pkg::GLYPH_COUNT];
  int          entry_w [bgrr_pkg::GLYPH_COUNT];
  int          entry_off [bgrr_pkg::GLYPH_COUNT];
  int          sh_height = 16;
  int          sh_used = 0;
  int          sh_reveal = 0;

  int          burst_left = 0;
  int          items_sent = 0;
  int          draws_sent = 0;
  int          settings_run = 0;
  int          quiet = 0;

  logic        hold_req = 1'b0;
  logic        hold_served = 1'b0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_stretch = 0;

  bitmap_glyph_row_rasterizer_core u_top (.*);

  glyph_row_checker u_rows (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .byte_address_i,
    .byte_value_i, .entry_index_i, .entry_width_i, .entry_offset_i, .glyph_i, .pos_x_i,
    .pos_y_i, .draw_color_i, .out_valid_i(out_valid_o), .out_ready_i,
    .row_x_i(row_x_o), .row_y_i(row_y_o), .pixel_mask_i(pixel_mask_o),
    .sparkle_mask_i(sparkle_mask_o), .pixel_color_i(pixel_color_o),
    .glyph_width_i(glyph_width_o), .last_row_i(last_row_o), .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .error_count, .rows_pending, .rows_checked
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // row sink: random stall modes, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_stretch = $urandom_range(10, 80);
      end
      rx_stretch--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 1) != 0);
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, giving up", $time, quiet);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic raster_cmd_t blank_cmd();
    raster_cmd_t c;
    c.cmd   = bgrr_pkg::CMD_NOP;
    c.addr  = 12'($urandom);
    c.value = 8'($urandom);
    c.idx   = 4'($urandom);
    c.w     = 6'($urandom_range(0, 55));
    c.off   = 12'($urandom);
    c.glyph = 8'($urandom);
    c.x     = 8'($urandom);
    c.y     = 8'($urandom);
    c.color = 16'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t font_byte_cmd(input int a, input int v);
    raster_cmd_t c;
    c = blank_cmd();
    c.cmd = bgrr_pkg::CMD_FONT_BYTE;
    c.addr = 12'(a);
    c.value = 8'(v);
    return c;
  endfunction

  function automatic raster_cmd_t glyph_entry_cmd(input int i, input int w, input int o);
    raster_cmd_t c;
    c = blank_cmd();
    c.cmd = bgrr_pkg::CMD_GLYPH_ENTRY;
    c.idx = 4'(i);
    c.w = 6'(w);
    c.off = 12'(o);
    return c;
  endfunction

  function automatic raster_cmd_t draw_cmd(input int g, input int x, input int y,
                                           input int col);
    raster_cmd_t c;
    c = blank_cmd();
    c.cmd = bgrr_pkg::CMD_DRAW;
    c.glyph = 8'(g);
    c.x = 8'(x);
    c.y = 8'(y);
    c.color = 16'(col);
    return c;
  endfunction

  // upper bound on the number of consecutive font bytes a draw of this entry touches
  function automatic int font_reads(input int w, input int off);
    int rows;
    int last_p;
    rows = sh_height;
    if (sh_reveal > 0 && sh_reveal < sh_height) rows = sh_reveal;
    if (rows > bgrr_pkg::MAX_ROWS) rows = bgrr_pkg::MAX_ROWS;
    if (rows == 0) return 0;
    last_p = sh_used - 1 - off;
    if (last_p < 0) last_p = 0;
    if (last_p > rows * (w / 8 + 1)) last_p = rows * (w / 8 + 1);
    return last_p + 1;
  endfunction

  function automatic int bytes_missing(input int w, input int off);
    int n;
    n = 0;
    for (int p = 0; p < font_reads(w, off); p++)
      if (!font_known[(off + p) % bgrr_pkg::FONT_BYTES]) n++;
    return n;
  endfunction

  function automatic bit glyph_ready(input int g);
    if (g >= bgrr_pkg::GLYPH_COUNT) return 1'b1;
    if (!entry_known[g]) return 1'b0;
    return bytes_missing(entry_w[g], entry_off[g]) == 0;
  endfunction

  task automatic send_item(input raster_cmd_t c);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    command_i      <= c.cmd;
    byte_address_i <= c.addr;
    byte_value_i   <= c.value;
    entry_index_i  <= c.idx;
    entry_width_i  <= c.w;
    entry_offset_i <= c.off;
    glyph_i        <= c.glyph;
    pos_x_i        <= c.x;
    pos_y_i        <= c.y;
    draw_color_i   <= c.color;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (c.cmd)
      bgrr_pkg::CMD_FONT_BYTE: begin
        font_known[c.addr] = 1'b1;
        items_sent++;
      end
      bgrr_pkg::CMD_GLYPH_ENTRY: begin
        if (c.idx < bgrr_pkg::GLYPH_COUNT) begin
          entry_known[c.idx] = 1'b1;
          entry_w[c.idx] = c.w;
          entry_off[c.idx] = c.off;
          items_sent++;
        end
      end
      bgrr_pkg::CMD_DRAW: begin
        items_sent++;
        draws_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic random_draw(input int g);
    int col;
    if (!glyph_ready(g)) g = $urandom_range(bgrr_pkg::GLYPH_COUNT, 255);
    col = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 65535);
    send_item(draw_cmd(g, $urandom, $urandom, col));
  endtask

  // load the font bytes an entry needs, point the entry at them, draw it
  task automatic glyph_sequence();
    int e;
    int w;
    int off;
    int addr;
    int v;
    bit found;
    e = $urandom_range(0, bgrr_pkg::GLYPH_COUNT - 1);
    found = 1'b0;
    for (int tries = 0; tries < 16 && !found; tries++) begin
      w = (tries < 8) ? $urandom_range(0, 55) : $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 0) begin
        off = $urandom_range(0, bgrr_pkg::FONT_BYTES - 1);
      end else begin
        off = sh_used - 1 - $urandom_range(0, 8);
        if (off < 0) off = $urandom_range(0, bgrr_pkg::FONT_BYTES - 1);
        off = off % bgrr_pkg::FONT_BYTES;
      end
      found = (bytes_missing(w, off) <= 20);
    end
    if (!found) return;
    for (int p = 0; p < font_reads(w, off); p++) begin
      addr = (off + p) % bgrr_pkg::FONT_BYTES;
      if (!font_known[addr]) begin
        case ($urandom_range(0, 3))
          0: v = 8'h00;
          1: v = 8'hFF;
          default: v = $urandom_range(0, 255);
        endcase
        send_item(font_byte_cmd(addr, v));
      end
    end
    send_item(glyph_entry_cmd(e, w, off));
    repeat ($urandom_range(1, 3)) random_draw(e);
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rows_pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input bgrr_pkg::cfg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[bgrr_pkg::CFG_W-1:0];
  endtask

  task automatic run_phase(input int height, input int used, input int reveal,
                           input int spk_en, input int spk_col, input int quota,
                           input bit long_hold);
    int start;
    int pick;
    wait_drained(8);
    write_reg(bgrr_pkg::CFG_FONT_HEIGHT, height);
    write_reg(bgrr_pkg::CFG_FONT_BYTES_USED, used);
    write_reg(bgrr_pkg::CFG_REVEAL_ROWS, reveal);
    write_reg(bgrr_pkg::CFG_SPARKLE_ENABLE, spk_en);
    write_reg(bgrr_pkg::CFG_SPARKLE_COLOR, spk_col);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_height = height;
    sh_used = used;
    sh_reveal = reveal;
    settings_run++;
    if (long_hold) hold_req <= 1'b1;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        glyph_sequence();
      else if (pick < 72)
        random_draw($urandom_range(0, bgrr_pkg::GLYPH_COUNT - 1));
      else if (pick < 76)
        random_draw($urandom_range(0, 255));
      else if (pick < 90)
        send_item(font_byte_cmd($urandom_range(0, bgrr_pkg::FONT_BYTES - 1),
                                $urandom_range(0, 255)));
      else if (pick < 97)
        send_item(glyph_entry_cmd($urandom_range(0, 15), $urandom_range(0, 55),
                                  $urandom_range(0, bgrr_pkg::FONT_BYTES - 1)));
      else
        send_item(blank_cmd());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 16 rows, no used bytes, so each row repeats the first byte
    send_item(font_byte_cmd(4095, 8'hA5));
    send_item(font_byte_cmd(0, 8'hFF));
    send_item(font_byte_cmd(12'hAAA, 8'h5A));
    send_item(font_byte_cmd(12'h555, 8'h00));
    send_item(glyph_entry_cmd(0, 55, 4095));
    send_item(glyph_entry_cmd(10, 0, 0));
    send_item(glyph_entry_cmd(15, 7, 12'h555));
    send_item(glyph_entry_cmd(5, 8, 12'hAAA));
    send_item(glyph_entry_cmd(3, 63 & 55, 12'h555));
    send_item(blank_cmd());
    send_item(draw_cmd(0, -128, 127, 16'hFFFF));
    send_item(draw_cmd(10, 127, -1, 16'h0000));
    send_item(draw_cmd(5, 0, -128, 16'h1234));
    send_item(draw_cmd(3, 1, 0, 16'hFFFF));
    send_item(draw_cmd(-128, 5, 3, 16'h8001));
    send_item(draw_cmd(127, -1, -1, 16'h7FFE));
    send_item(draw_cmd(11, 64, 64, 16'h00FF));
    send_item(draw_cmd(-1, 0, 0, 16'h0000));

    run_phase(16, 0, 0, 0, 16'hFFFF, 36, 1'b0);
    run_phase(8, 64, 0, 1, 16'hF800, 36, 1'b0);
    run_phase(32, 4096, 31, 1, 16'h0000, 40, 1'b1);
    run_phase(0, 100, 5, 1, 16'hFFFF, 30, 1'b0);
    run_phase(45, 0, 0, 1, 16'h07E0, 36, 1'b0);
    run_phase(6, 8191, 0, 1, 16'h001F, 40, 1'b0);
    run_phase(12, 200, 3, 0, 16'hAAAA, 40, 1'b0);

    wait_drained(40);
    $display("Covered %0d load/draw transfers (%0d draws) across %0d register settings,",
             items_sent, draws_sent, settings_run);
    $display("with %0d glyph rows compared and %0d errors.", rows_checked, error_count);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* bitmap_glyph_row_rasterizer_core.f */
rtl/bgrr_pkg.sv
rtl/bgrr_ram.sv
rtl/bgrr_sparkle.sv
rtl/bgrr_engine.sv
rtl/bitmap_glyph_row_rasterizer_core.sv
rtl/bgrr_checker.sv
test/glyph_row_checker.sv
test/bitmap_glyph_row_rasterizer_core_test.sv
